FILE: design/dcm_pkg.sv
// shared types, constants and a helper function for the diode companion model core
// no dependencies; imported by dcm_wmul and diode_companion_model_core
`default_nettype none

package dcm_pkg;

   // fixed-point formats
   localparam int VOLTAGE_FRAC_BITS = 24;
   localparam int X_SHIFT = 2 * VOLTAGE_FRAC_BITS - 32;  // v*inv down to Q32
   localparam int G_SHIFT = VOLTAGE_FRAC_BITS + 8;       // ise*inv down to conductance lsb
   localparam int V_SHIFT = VOLTAGE_FRAC_BITS - 8;       // g*|v| down to current lsb

   // shared multiplier geometry
   localparam int WIDE_W = 64;
   localparam int PART_W = 32;

   // arithmetic constants
   localparam logic [63:0] MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] TOP64  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
   localparam logic [63:0] LOG2E_Q32 = 64'h0000_0001_7154_7653;
   localparam logic [63:0] LN2_Q62 = 64'h2C5C_85FD_F473_DE6B;
   localparam logic [15:0] EXP_HIGH_INT = 16'd44;
   localparam logic [15:0] EXP_LOW_INT = 16'd64;
   localparam logic [4:0] TAYLOR_TERMS = 5'd30;

   // reset values of state and registers
   localparam logic [31:0] GUESS_RESET = 32'd11744051;
   localparam logic [62:0] IS_RESET = 63'd721;
   localparam logic [24:0] VT_RESET = 25'd419430;
   localparam logic [31:0] INV_RESET = 32'd671088640;

   // command codes
   localparam logic [1:0] CMD_SIM_BEGIN = 2'd0;
   localparam logic [1:0] CMD_STEP_BEGIN = 2'd1;
   localparam logic [1:0] CMD_ITERATE = 2'd2;
   localparam logic [1:0] CMD_SPARE = 2'd3;   // spare code, runs as iterate

   // register indexes
   localparam logic [1:0] REG_SAT_CURRENT = 2'd0;
   localparam logic [1:0] REG_THERMAL_V = 2'd1;
   localparam logic [1:0] REG_INV_THERMAL_V = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LIMIT,
      S_XMUL,
      S_YMUL,
      S_TMUL,
      S_TAYMUL,
      S_TAYDIV,
      S_PMUL,
      S_PCHK,
      S_GMUL,
      S_VMUL,
      S_FINAL
   } state_type;

   typedef struct packed {
      logic        ovf;
      logic [63:0] value;
   } sat_type;

   // a minus b, b in sign and magnitude, saturated to int64; huge means |b| >= 2^64
   function automatic sat_type sub_sat(input logic [63:0] a, input logic b_neg,
                                       input logic [63:0] b_mag, input logic huge);
      sat_type     r;
      logic [63:0] ao;
      ao = a ^ TOP64;
      if (!b_neg) begin
         if (huge || (b_mag > ao)) begin
            r.ovf = 1'b1;
            r.value = TOP64;
         end else begin
            r.ovf = 1'b0;
            r.value = (ao - b_mag) ^ TOP64;
         end
      end else begin
         if (huge || (b_mag > ~ao)) begin
            r.ovf = 1'b1;
            r.value = MAX64;
         end else begin
            r.ovf = 1'b0;
            r.value = (ao + b_mag) ^ TOP64;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/dcm_wmul.sv
// shared 64x64 unsigned multiplier built from one 32x32 multiplier over four steps
// depends on dcm_pkg for the operand and part widths
`default_nettype none

module dcm_wmul
   import dcm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [WIDE_W-1:0]     a,
   input  wire logic [WIDE_W-1:0]     b,
   output logic                       done,
   output logic [2*WIDE_W-1:0]        product
);

   logic [WIDE_W-1:0]   a_ff, a_in;
   logic [WIDE_W-1:0]   b_ff, b_in;
   logic [2:0]          step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                pvld_ff, pvld_in;
   logic [1:0]          psh_ff, psh_in;
   logic [2*PART_W-1:0] prod_ff, prod_in;
   logic [2*WIDE_W-1:0] acc_ff, acc_in;
   logic                done_ff, done_in;

   assign done = done_ff;
   assign product = acc_ff;

   // partial product sequencing and accumulation
   always_comb begin
      logic [PART_W-1:0]   a_part;
      logic [PART_W-1:0]   b_part;
      logic [2*WIDE_W-1:0] addend;
      a_in = a_ff;
      b_in = b_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      pvld_in = 1'b0;
      psh_in = psh_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      done_in = 1'b0;
      a_part = step_ff[1] ? a_ff[WIDE_W-1:PART_W] : a_ff[PART_W-1:0];
      b_part = step_ff[0] ? b_ff[WIDE_W-1:PART_W] : b_ff[PART_W-1:0];
      addend = {{(2*WIDE_W-2*PART_W){1'b0}}, prod_ff} << {psh_ff, 5'b00000};
      if (start) begin
         a_in = a;
         b_in = b;
         step_in = 3'd0;
         busy_in = 1'b1;
         acc_in = '0;
      end else if (busy_ff) begin
         if (pvld_ff) begin
            acc_in = acc_ff + addend;
         end
         if (step_ff[2]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            prod_in = a_part * b_part;
            psh_in = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
            pvld_in = 1'b1;
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pvld_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         pvld_ff <= pvld_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      psh_ff <= psh_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

FILE: design/diode_companion_model_core.sv
// Shockley diode companion model for Newton-Raphson simulation: one command
// item in, one stamp item out. Each item walks a sequencer through about 36
// wide products on one shared 32x32 multiplier and a 30-term Taylor series
// for 2^f whose terms are each divided by the term index; the Taylor series
// dominates the run time of an item.
// When Is is zero or the exponent is out of range the series is skipped.
// The block takes no new item until the current one is finished, and the
// result waits in an output register while the next item is accepted.
// Registers are written through the csr port, which is ready only while idle.
// depends on dcm_pkg and dcm_wmul
`default_nettype none

module diode_companion_model_core
   import dcm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // command items
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // anode_voltage[31:0], cathode_voltage[63:32]
   input  wire logic [1:0]   req_tuser,   // command[1:0]
   // result items
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [167:0]      rsp_tdata,   // conductance_stamp[63:0], current_stamp[127:64],
                                          // used_voltage[159:128], step_limited[160],
                                          // overflow[161], zero pad[167:162]
   // register writes
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [63:0]  csr_data
);

   state_type     state_ff, state_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [31:0]   guess_ff, guess_in;
   logic [31:0]   prev_ff, prev_in;
   logic [31:0]   v_ff, v_in;
   logic          lim_ff, lim_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    n_ff, n_in;
   logic [63:0]   t_ff, t_in;
   logic [63:0]   m_ff, m_in;
   logic [4:0]    k_ff, k_in;
   logic [4:0]    rem_ff, rem_in;
   logic [63:0]   dnum_ff, dnum_in;
   logic [3:0]    dcnt_ff, dcnt_in;
   logic [63:0]   plo_ff, plo_in;
   logic          phi_ff, phi_in;
   logic [63:0]   cur_ff, cur_in;
   logic [63:0]   g_ff, g_in;
   logic [63:0]   ieq_ff, ieq_in;
   logic [63:0]   gnow_ff, gnow_in;
   logic [63:0]   inow_ff, inow_in;
   logic [62:0]   is_ff, is_in;
   logic [24:0]   vt_ff, vt_in;
   logic [31:0]   inv_ff, inv_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [167:0]  rsp_data_ff, rsp_data_in;

   logic          mul_start;
   logic [63:0]   mul_a;
   logic [63:0]   mul_b;
   logic          mul_done;
   logic [127:0]  mul_p;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign csr_ready = (state_ff == S_IDLE);

   dcm_wmul u_wmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   // sequencer and datapath next values
   always_comb begin
      logic signed [32:0] node_d;
      logic signed [32:0] step_d;
      logic signed [32:0] vt_s;
      logic [31:0]        v_new;
      logic [31:0]        vnew_mag;
      logic [31:0]        v_mag;
      logic               v_neg;
      logic [47:0]        xmag;
      logic [63:0]        ymag;
      logic [6:0]         nmag;
      logic               f_zero;
      logic [31:0]        f_val;
      logic signed [7:0]  n_val;
      logic signed [8:0]  s_val;
      logic [127:0]       p_sh;
      logic [5:0]         r6;
      logic [4:0]         r5;
      logic [63:0]        q;
      logic [63:0]        m_next;
      logic [64:0]        pdiff;
      logic [63:0]        ise;
      logic [63:0]        cur_v;
      logic               big;
      sat_type            sat_i;
      sat_type            sat_g;
      logic               i_neg;
      logic [63:0]        i_mag;
      logic [63:0]        out_g;
      logic [63:0]        out_i;
      logic               out_ovf;

      state_in = state_ff;
      cmd_in = cmd_ff;
      guess_in = guess_ff;
      prev_in = prev_ff;
      v_in = v_ff;
      lim_in = lim_ff;
      ovf_in = ovf_ff;
      n_in = n_ff;
      t_in = t_ff;
      m_in = m_ff;
      k_in = k_ff;
      rem_in = rem_ff;
      dnum_in = dnum_ff;
      dcnt_in = dcnt_ff;
      plo_in = plo_ff;
      phi_in = phi_ff;
      cur_in = cur_ff;
      g_in = g_ff;
      ieq_in = ieq_ff;
      gnow_in = gnow_ff;
      inow_in = inow_ff;
      is_in = is_ff;
      vt_in = vt_ff;
      inv_in = inv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      mul_start = 1'b0;
      mul_a = '0;
      mul_b = '0;

      node_d = $signed({req_tdata[31], req_tdata[31:0]})
             - $signed({req_tdata[63], req_tdata[63:32]});
      step_d = $signed({guess_ff[31], guess_ff}) - $signed({prev_ff[31], prev_ff});
      vt_s = $signed({8'b0, vt_ff});
      v_new = guess_ff;
      vnew_mag = '0;
      v_neg = v_ff[31];
      v_mag = v_neg ? (32'd0 - v_ff) : v_ff;
      xmag = mul_p[X_SHIFT +: 48];
      ymag = mul_p[95:32];
      nmag = ymag[38:32];
      f_zero = (ymag[31:0] == 32'd0);
      f_val = ymag[31:0];
      n_val = $signed({1'b0, nmag});
      s_val = 9'sd62 - $signed({n_ff[7], n_ff});
      p_sh = s_val[8] ? (mul_p << 1) : (mul_p >> s_val[7:0]);
      r5 = rem_ff;
      r6 = '0;
      q = dnum_ff;
      m_next = '0;
      pdiff = {1'b0, plo_ff} - {2'b0, is_ff};
      ise = '0;
      cur_v = '0;
      big = 1'b0;
      sat_i = sub_sat(cur_ff, v_neg, mul_p[V_SHIFT +: 64], |mul_p[127:V_SHIFT+64]);
      i_neg = inow_ff[63];
      i_mag = i_neg ? (64'd0 - inow_ff) : inow_ff;
      sat_g = sub_sat(g_ff, 1'b0, gnow_ff, 1'b0);
      out_g = g_ff;
      out_i = ieq_ff;
      out_ovf = ovf_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SAT_CURRENT: is_in = csr_data[62:0];
            REG_THERMAL_V: vt_in = csr_data[24:0];
            REG_INV_THERMAL_V: inv_in = csr_data[31:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         // take a command, form the new guess or restart from it
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tuser;
               ovf_in = 1'b0;
               if (req_tuser >= CMD_ITERATE) begin
                  if (node_d[32] != node_d[31]) begin
                     guess_in = node_d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                  end else begin
                     guess_in = node_d[31:0];
                  end
               end else begin
                  prev_in = guess_ff;
               end
               state_in = S_LIMIT;
            end
         end
         // clamp the step to one thermal voltage, then v*inv
         S_LIMIT: begin
            lim_in = 1'b0;
            if (step_d > vt_s) begin
               v_new = prev_ff + {7'b0, vt_ff};
               lim_in = 1'b1;
            end else if (step_d < -vt_s) begin
               v_new = prev_ff - {7'b0, vt_ff};
               lim_in = 1'b1;
            end
            v_in = v_new;
            prev_in = v_new;
            vnew_mag = v_new[31] ? (32'd0 - v_new) : v_new;
            mul_start = 1'b1;
            mul_a = {32'b0, vnew_mag};
            mul_b = {32'b0, inv_ff};
            state_in = S_XMUL;
         end
         // zero-Is and exponent range checks, else x*log2(e)
         S_XMUL: begin
            if (mul_done) begin
               mul_start = 1'b1;
               if (is_ff == 63'd0) begin
                  cur_in = '0;
                  mul_a = '0;
                  mul_b = {32'b0, inv_ff};
                  state_in = S_GMUL;
               end else if (!v_neg && (xmag[47:32] >= EXP_HIGH_INT)) begin
                  ovf_in = 1'b1;
                  cur_in = MAX64;
                  mul_a = MAX64 + {1'b0, is_ff};
                  mul_b = {32'b0, inv_ff};
                  state_in = S_GMUL;
               end else if (v_neg && (xmag[47:32] >= EXP_LOW_INT)) begin
                  cur_in = 64'd0 - {1'b0, is_ff};
                  mul_a = '0;
                  mul_b = {32'b0, inv_ff};
                  state_in = S_GMUL;
               end else begin
                  mul_a = {16'b0, xmag};
                  mul_b = LOG2E_Q32;
                  state_in = S_YMUL;
               end
            end
         end
         // split into integer and fraction, then f*ln2
         S_YMUL: begin
            if (mul_done) begin
               if (v_neg) begin
                  n_val = -$signed({1'b0, nmag});
                  if (!f_zero) begin
                     n_val = n_val - 8'sd1;
                     f_val = 32'd0 - ymag[31:0];
                  end
               end
               n_in = n_val;
               mul_start = 1'b1;
               mul_a = {32'b0, f_val};
               mul_b = LN2_Q62;
               state_in = S_TMUL;
            end
         end
         // start the series with the first term
         S_TMUL: begin
            if (mul_done) begin
               t_in = mul_p[95:32];
               m_in = ONE_Q62;
               k_in = 5'd1;
               mul_start = 1'b1;
               mul_a = ONE_Q62;
               mul_b = mul_p[95:32];
               state_in = S_TAYMUL;
            end
         end
         // previous term times t, ready for the divide
         S_TAYMUL: begin
            if (mul_done) begin
               dnum_in = mul_p[125:62];
               rem_in = '0;
               dcnt_in = '0;
               state_in = S_TAYDIV;
            end
         end
         // restoring divide by k, four quotient bits a cycle
         S_TAYDIV: begin
            for (int j = 0; j < 4; j++) begin
               r6 = {r5, q[63]};
               q = {q[62:0], 1'b0};
               if (r6 >= {1'b0, k_ff}) begin
                  r6 = r6 - {1'b0, k_ff};
                  q[0] = 1'b1;
               end
               r5 = r6[4:0];
            end
            dnum_in = q;
            rem_in = r5;
            dcnt_in = dcnt_ff + 4'd1;
            if (dcnt_ff == 4'd15) begin
               m_next = m_ff + q;
               m_in = m_next;
               mul_start = 1'b1;
               if (k_ff == TAYLOR_TERMS) begin
                  mul_a = {1'b0, is_ff};
                  mul_b = m_next;
                  state_in = S_PMUL;
               end else begin
                  k_in = k_ff + 5'd1;
                  mul_a = q;
                  mul_b = t_ff;
                  state_in = S_TAYMUL;
               end
            end
         end
         // scale Is*2^f by 2^n
         S_PMUL: begin
            if (mul_done) begin
               plo_in = p_sh[63:0];
               phi_in = |p_sh[127:64];
               state_in = S_PCHK;
            end
         end
         // current with saturation, then (I+Is)*inv
         S_PCHK: begin
            big = phi_ff || (!pdiff[64] && pdiff[63]);
            if (big) begin
               ovf_in = 1'b1;
               ise = MAX64 + {1'b0, is_ff};
               cur_v = MAX64;
            end else begin
               ise = plo_ff;
               cur_v = pdiff[63:0];
            end
            cur_in = cur_v;
            mul_start = 1'b1;
            mul_a = ise;
            mul_b = {32'b0, inv_ff};
            state_in = S_GMUL;
         end
         // conductance with saturation, then g*|v|
         S_GMUL: begin
            if (mul_done) begin
               if (|mul_p[127:G_SHIFT+63]) begin
                  ovf_in = 1'b1;
                  g_in = MAX64;
                  mul_a = MAX64;
               end else begin
                  g_in = mul_p[G_SHIFT +: 64];
                  mul_a = mul_p[G_SHIFT +: 64];
               end
               mul_start = 1'b1;
               mul_b = {32'b0, v_mag};
               state_in = S_VMUL;
            end
         end
         // equivalent current
         S_VMUL: begin
            if (mul_done) begin
               ieq_in = sat_i.value;
               ovf_in = ovf_ff | sat_i.ovf;
               state_in = S_FINAL;
            end
         end
         // absolute or delta stamps into the output register
         S_FINAL: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (cmd_ff != CMD_SIM_BEGIN) begin
                  sat_i = sub_sat(ieq_ff, i_neg, i_mag, 1'b0);
                  out_g = sat_g.value;
                  out_i = sat_i.value;
                  out_ovf = ovf_ff | sat_g.ovf | sat_i.ovf;
               end
               gnow_in = g_ff;
               inow_in = ieq_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in = {6'b0, out_ovf, lim_ff, v_ff, out_i, out_g};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         guess_ff <= GUESS_RESET;
         prev_ff <= '0;
         gnow_ff <= '0;
         inow_ff <= '0;
         is_ff <= IS_RESET;
         vt_ff <= VT_RESET;
         inv_ff <= INV_RESET;
         dcnt_ff <= '0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         guess_ff <= guess_in;
         prev_ff <= prev_in;
         gnow_ff <= gnow_in;
         inow_ff <= inow_in;
         is_ff <= is_in;
         vt_ff <= vt_in;
         inv_ff <= inv_in;
         dcnt_ff <= dcnt_in;
         k_ff <= k_in;
      end
      cmd_ff <= cmd_in;
      v_ff <= v_in;
      lim_ff <= lim_in;
      ovf_ff <= ovf_in;
      n_ff <= n_in;
      t_ff <= t_in;
      m_ff <= m_in;
      rem_ff <= rem_in;
      dnum_ff <= dnum_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      cur_ff <= cur_in;
      g_ff <= g_in;
      ieq_ff <= ieq_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
